// ===== src/pairwise_manhattan_distance_sum_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for pairwise_manhattan_distance_sum
// Shared property wrappers; clock and reset names are fixed by the project.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_MANHATTAN_DISTANCE_SUM_DEFINES_SVH
`define PAIRWISE_MANHATTAN_DISTANCE_SUM_DEFINES_SVH

// same-cycle implication
`define PMDS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pmds assertion failed");

// next-cycle implication
`define PMDS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmds assertion failed");

`endif

// ===== src/pmds_pkg.sv =====
// ----------------------------------------------------------------------------
// pmds_pkg
// Shared constants and types for the pairwise Manhattan distance sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmds_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 32;

   localparam int SUM_BITS = 52;
   localparam int CNT_OUT_BITS = 11;
   localparam logic [SUM_BITS-1:0] SUM_CAP = {SUM_BITS{1'b1}};
   localparam int CNT_OUT_CAP = 2047;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_OUTER,
      ST_HOLD,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // control from the sequencer to the accumulator
   typedef struct packed {
      logic valid;
      logic clear;
   } ctl_type;

endpackage

`default_nettype wire

// ===== src/pmds_accum.sv =====
// ----------------------------------------------------------------------------
// pmds_accum
// Pipelined |dx|+|dy| term and saturating 52-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pmds_accum #(
   parameter int COORD_BITS = pmds_pkg::COORD_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire pmds_pkg::ctl_type       ctl,
   input  wire [COORD_BITS-1:0]         xa,
   input  wire [COORD_BITS-1:0]         ya,
   input  wire [COORD_BITS-1:0]         xb,
   input  wire [COORD_BITS-1:0]         yb,
   output logic                         busy,
   output logic [pmds_pkg::SUM_BITS-1:0] acc
);

   localparam int SB = pmds_pkg::SUM_BITS;

   logic [COORD_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [COORD_BITS:0]   term_ff, term_in;
   logic                  v1_ff, v2_ff;
   logic [SB-1:0]         acc_ff;
   logic [SB:0]           sum;

   // offset-binary values: plain unsigned differences
   always_comb begin
      dx_in = (xa >= xb) ? (xa - xb) : (xb - xa);
      dy_in = (ya >= yb) ? (ya - yb) : (yb - ya);
      term_in = {1'b0, dx_ff} + {1'b0, dy_ff};
      sum = {1'b0, acc_ff} + (SB+1)'(term_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      term_ff <= term_in;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= sum[SB] ? pmds_pkg::SUM_CAP : sum[SB-1:0];
      end
   end

   assign busy = v1_ff | v2_ff;
   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== src/pairwise_manhattan_distance_sum.sv =====
// ----------------------------------------------------------------------------
// pairwise_manhattan_distance_sum
// Sum of |xi-xj|+|yi-yj| over all unordered pairs of a loaded point set.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one point per transfer (req_x_coord, req_y_coord, two's
//   complement in COORD_BITS bits). req_last_point closes the set.
//   Loading takes one cycle per point; req_stall is low only while loading.
//   Up to MAX_POINTS points are kept; later ones are dropped and reported
//   through rsp_overflow.
//   After the closing point the block walks all pairs out of the point
//   memories: for each i it fetches point i through ST_OUTER and ST_HOLD,
//   then spends one cycle per partner j > i, reading one memory entry per
//   cycle. The single read port of the point memories sets the length of
//   the walk; with fewer than two kept points the walk is skipped.
//   rsp_ channel: one transfer per set with rsp_total_distance (saturates at
//   2^52-1), rsp_point_count (saturates at 2047) and rsp_overflow. While
//   rsp_stall is high the result holds steady; after its transfer the store
//   is emptied and loading resumes.
//   Reset (synchronous, active high) empties the store; no clearing pass is
//   needed since only entries written in the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_manhattan_distance_sum #(
   parameter int MAX_POINTS = pmds_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = pmds_pkg::COORD_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire signed [COORD_BITS-1:0]        req_x_coord,
   input  wire signed [COORD_BITS-1:0]        req_y_coord,
   input  wire                                req_last_point,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [pmds_pkg::SUM_BITS-1:0]      rsp_total_distance,
   output logic [pmds_pkg::CNT_OUT_BITS-1:0]  rsp_point_count,
   output logic                               rsp_overflow
);

`include "pairwise_manhattan_distance_sum_defines.svh"

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   pmds_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_after;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic          drop_ff, drop_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          wr_en, lat_i, room, clr;
   logic [AW-1:0] rd_addr;

   // point memories, offset-binary so unsigned order equals signed order
   logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] rd_x_ff, rd_y_ff, xi_ff, yi_ff;

   logic [COORD_BITS-1:0] sign_flip;
   assign sign_flip = {1'b1, {(COORD_BITS-1){1'b0}}};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[cnt_ff[AW-1:0]] <= req_x_coord ^ sign_flip;
         y_mem[cnt_ff[AW-1:0]] <= req_y_coord ^ sign_flip;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
      if (lat_i) begin
         xi_ff <= rd_x_ff;
         yi_ff <= rd_y_ff;
      end
   end

   pmds_pkg::ctl_type ctl;
   logic acc_busy;
   logic [pmds_pkg::SUM_BITS-1:0] acc;

   assign ctl.valid = rd_vld_ff;
   assign ctl.clear = clr;

   pmds_accum #(
      .COORD_BITS(COORD_BITS)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .xa(rd_x_ff),
      .ya(rd_y_ff),
      .xb(xi_ff),
      .yb(yi_ff),
      .busy(acc_busy),
      .acc(acc)
   );

   // sequencer: load, pair walk i < j, drain, then response
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      drop_in = drop_ff;
      i_in = i_ff;
      j_in = j_ff;
      rd_addr = i_ff[AW-1:0];
      rd_vld_in = 1'b0;
      wr_en = 1'b0;
      lat_i = 1'b0;
      clr = 1'b0;
      room = cnt_ff < CW'(MAX_POINTS);
      cnt_after = room ? cnt_ff + CW'(1) : cnt_ff;
      unique case (state_ff)
         pmds_pkg::ST_LOAD: begin
            if (req_valid) begin
               wr_en = room;
               cnt_in = cnt_after;
               if (!room) drop_in = 1'b1;
               if (req_last_point) begin
                  clr = 1'b1;
                  i_in = '0;
                  state_in = (cnt_after < CW'(2)) ? pmds_pkg::ST_DRAIN
                                                  : pmds_pkg::ST_OUTER;
               end
            end
         end
         pmds_pkg::ST_OUTER: begin
            state_in = pmds_pkg::ST_HOLD;
         end
         pmds_pkg::ST_HOLD: begin
            lat_i = 1'b1;
            j_in = i_ff + CW'(1);
            state_in = pmds_pkg::ST_SCAN;
         end
         pmds_pkg::ST_SCAN: begin
            rd_addr = j_ff[AW-1:0];
            rd_vld_in = 1'b1;
            j_in = j_ff + CW'(1);
            if (j_ff == cnt_ff - CW'(1)) begin
               i_in = i_ff + CW'(1);
               state_in = (i_ff + CW'(2) == cnt_ff) ? pmds_pkg::ST_DRAIN
                                                    : pmds_pkg::ST_OUTER;
            end
         end
         pmds_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !acc_busy) state_in = pmds_pkg::ST_RESP;
         end
         pmds_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               cnt_in = '0;
               drop_in = 1'b0;
               state_in = pmds_pkg::ST_LOAD;
            end
         end
         default: state_in = pmds_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmds_pkg::ST_LOAD;
         cnt_ff <= '0;
         drop_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         drop_ff <= drop_in;
         rd_vld_ff <= rd_vld_in;
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   assign req_stall = (state_ff != pmds_pkg::ST_LOAD);
   assign rsp_valid = (state_ff == pmds_pkg::ST_RESP);
   assign rsp_total_distance = acc;
   assign rsp_point_count = (32'(cnt_ff) > 32'(pmds_pkg::CNT_OUT_CAP))
                          ? pmds_pkg::CNT_OUT_BITS'(pmds_pkg::CNT_OUT_CAP)
                          : pmds_pkg::CNT_OUT_BITS'(cnt_ff);
   assign rsp_overflow = drop_ff;

   `PMDS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= CW'(MAX_POINTS))
   `PMDS_ASSERT_NEXT(a_rsp_empties, rsp_valid && !rsp_stall, cnt_ff == '0 && !drop_ff)
   `PMDS_ASSERT_NOW(a_scan_range, state_ff == pmds_pkg::ST_SCAN, j_ff > i_ff && j_ff < cnt_ff)
   `PMDS_ASSERT_NOW(a_resp_idle, rsp_valid, !rd_vld_ff && !acc_busy)

endmodule

`default_nettype wire

// ===== tb/tb_pairwise_manhattan_distance_sum.sv =====
// ----------------------------------------------------------------------------
// tb_pairwise_manhattan_distance_sum
// Loads point sets through the req_ channel and checks each set's
// result against a direct pairwise sum computed in the bench. Covers
// coordinate extremes, single-point and duplicate sets, a set that
// overruns the store, random sets, and a long rsp_ hold-off that
// stalls the block's input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pairwise_manhattan_distance_sum;

   localparam int CAPACITY = pmds_pkg::MAX_POINTS_DEF;
   localparam int RANDOM_ITEMS = 1250;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [pmds_pkg::SUM_BITS-1:0]     total;
      logic [pmds_pkg::CNT_OUT_BITS-1:0] count;
      logic                              overflow;
   } set_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_x_coord;
   logic signed [31:0] req_y_coord;
   logic req_last_point;
   logic rsp_valid;
   logic rsp_stall;
   logic [pmds_pkg::SUM_BITS-1:0] rsp_total_distance;
   logic [pmds_pkg::CNT_OUT_BITS-1:0] rsp_point_count;
   logic rsp_overflow;

   // points kept for the set being loaded
   int set_x[$];
   int set_y[$];
   bit set_dropped;
   set_result_type pending_sums[$];

   int  errors;
   int  items_sent;
   bit  no_idle;       // sender and receiver run without gaps
   bit  hold_request;  // receiver does one long hold-off

   pairwise_manhattan_distance_sum dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_distance (rsp_total_distance),
      .rsp_point_count    (rsp_point_count),
      .rsp_overflow       (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Direct O(N^2) sum over unordered pairs; the result only depends on the
   // set, so this matches the block's pairwise walk exactly.
   function automatic set_result_type pairwise_sum();
      set_result_type r;
      longint unsigned acc;
      longint dx, dy;
      acc = 0;
      for (int i = 0; i < set_x.size(); i++) begin
         for (int j = i + 1; j < set_x.size(); j++) begin
            dx = longint'(set_x[i]) - longint'(set_x[j]);
            dy = longint'(set_y[i]) - longint'(set_y[j]);
            acc += (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
         end
      end
      r.total = (acc > longint'(pmds_pkg::SUM_CAP)) ? pmds_pkg::SUM_CAP
                                                     : acc[pmds_pkg::SUM_BITS-1:0];
      r.count = (set_x.size() > pmds_pkg::CNT_OUT_CAP)
              ? pmds_pkg::CNT_OUT_BITS'(pmds_pkg::CNT_OUT_CAP)
              : pmds_pkg::CNT_OUT_BITS'(set_x.size());
      r.overflow = set_dropped;
      return r;
   endfunction

   // update the bench's copy of the store for one accepted transfer
   task automatic load_point(input int x, input int y, input bit last);
      if (set_x.size() < CAPACITY) begin
         set_x.insert(set_x.size(), x);
         set_y.insert(set_y.size(), y);
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         pending_sums.insert(pending_sums.size(), pairwise_sum());
         set_x.delete();
         set_y.delete();
         set_dropped = 1'b0;
      end
   endtask

   // Offer one point; valid stays high across back-to-back transfers.
   task automatic send_point(input int x, input int y, input bit last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(11, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_coord    <= x;
      req_y_coord    <= y;
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
      load_point(x, y, last);
      items_sent++;
   endtask

   function automatic int pick_coord(input int mode);
      case (mode)
         0:       return int'($urandom());
         1:       return $urandom_range(40, 0) - 20;
         2:       return $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return int'($urandom_range(65535, 0)) - 32768;
      endcase
   endfunction

   task automatic send_set(input int n, input int mode);
      for (int i = 0; i < n; i++)
         send_point(pick_coord(mode), pick_coord(mode), i == n - 1);
   endtask

   // corners of the coordinate range, single points, duplicates
   task automatic test_extremes();
      send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
      send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
      send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(-1, -1, 1'b1);
      send_point(5, -7, 1'b0);
      send_point(5, -7, 1'b0);
      send_point(5, -7, 1'b1);
      send_point(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
      send_point(32'haaaa_aaaa, 32'h5555_5555, 1'b1);
   endtask

   // fill the store, then drop two points, the closing one among them
   task automatic test_overflow();
      send_set(CAPACITY + 2, 0);
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int s = 0; s < 6; s++) send_set($urandom_range(6, 1), 0);
   endtask

   task automatic test_random();
      while (items_sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(7, 0) == 0);
         if ($urandom_range(9, 0) == 0) send_set($urandom_range(60, 17), $urandom_range(3, 0));
         else send_set($urandom_range(16, 1), $urandom_range(3, 0));
      end
      no_idle = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      set_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result total=%0d count=%0d overflow=%0b",
                     $time, rsp_total_distance, rsp_point_count, rsp_overflow);
            errors++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_total_distance !== want.total) begin
               $display("%0t: total_distance expected %0d actual %0d",
                        $time, want.total, rsp_total_distance);
               errors++;
            end
            if (rsp_point_count !== want.count) begin
               $display("%0t: point_count expected %0d actual %0d",
                        $time, want.count, rsp_point_count);
               errors++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b actual %0b",
                        $time, want.overflow, rsp_overflow);
               errors++;
            end
         end
      end
   end

   // Receiver: random stall before each result, or one long hold-off on
   // request while the sender keeps offering points.
   initial begin
      int n;
      rsp_stall <= 1'b1;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            n = LONG_HOLD;
            hold_request = 1'b0;
         end else begin
            n = no_idle ? 0 : $urandom_range(11, 0);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #30_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      errors = 0;
      items_sent = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      set_dropped = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_x_coord <= '0;
      req_y_coord <= '0;
      req_last_point <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_backpressure();
      test_overflow();
      test_random();

      req_valid <= 1'b0;
      wait (pending_sums.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
